FILE: sv/multi_deque_transfer_engine_assert.svh
// assertion macros for the multi deque transfer engine
// expects clk and arst_n in the including module, no other dependency
`ifndef MULTI_DEQUE_TRANSFER_ENGINE_ASSERT_SVH
`define MULTI_DEQUE_TRANSFER_ENGINE_ASSERT_SVH

// same-cycle implication
`define MDTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MDTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mdte_pkg.sv
// shared constants and types for the multi deque transfer engine
// no dependencies
package mdte_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int QUEUE_COUNT_DEF = 8;
	localparam int VALUE_WIDTH_DEF = 8;

	// fixed port field widths
	localparam int VALUE_FIELD_W = 8;
	localparam int QIDX_FIELD_W  = 3;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_EMPTY     = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_BAD_INDEX = 2'd3
	} status_t;

endpackage

FILE: sv/mdte_ram.sv
// generic single-write, single-read ram with registered read data
// depends on mdte_pkg for default sizes only
module mdte_ram #(
	parameter int WIDTH = mdte_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH = mdte_pkg::QUEUE_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/multi_deque_transfer_engine.sv
// bank of circular deques sharing one entry ram, pointer records in a second ram
// depends on mdte_pkg, mdte_ram and multi_deque_transfer_engine_assert.svh
//
//  channel  | handshake              | fields
//  ---------+------------------------+---------------------------------------------
//  command  | start, busy            | mode value source_queue pop_side dest_queue
//           |                        | push_side
//  result   | done (one-cycle pulse) | moved_value status
//
// a word is taken at a clock edge with start high and busy low
// load and any refused word: busy in ST_META1 and ST_META2; move within one queue: also
// in ST_POP; move between two queues: busy in ST_META1, ST_META2, ST_POP and ST_SRCWB
// the busy time comes from the single read port of the pointer ram (source record, then
// destination record) plus the registered read of the entry ram for the popped word
// done is high for one cycle, registered from the decision for a load or a refused word,
// and from the entry ram write for a move; the receiver cannot stall
// reset leaves all queues empty through per-queue valid bits, no clearing pass
`include "multi_deque_transfer_engine_assert.svh"

module multi_deque_transfer_engine #(
	parameter int QUEUE_DEPTH = mdte_pkg::QUEUE_DEPTH_DEF,
	parameter int QUEUE_COUNT = mdte_pkg::QUEUE_COUNT_DEF,
	parameter int VALUE_WIDTH = mdte_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [mdte_pkg::VALUE_FIELD_W-1:0]  value,
	input  logic [mdte_pkg::QIDX_FIELD_W-1:0]   source_queue,
	input  logic                                pop_side,
	input  logic [mdte_pkg::QIDX_FIELD_W-1:0]   dest_queue,
	input  logic                                push_side,
	output logic                                done,
	output logic [mdte_pkg::VALUE_FIELD_W-1:0]  moved_value,
	output logic [1:0]                          status
);

	localparam int PW     = $clog2(QUEUE_DEPTH);
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int QIW    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int EDEPTH = QUEUE_COUNT * QUEUE_DEPTH;
	localparam int EAW    = $clog2(EDEPTH);

	typedef struct packed {
		logic [PW-1:0] front;
		logic [PW-1:0] rear;
		logic [CW-1:0] count;
	} meta_t;

	localparam int MW = $bits(meta_t);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_META1 = 5'b00010,
		ST_META2 = 5'b00100,
		ST_POP   = 5'b01000,
		ST_SRCWB = 5'b10000
	} state_t;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		ptr_dec = (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
	endfunction

	state_t state_q, state_d;

	// latched command word
	logic                                 mode_q;
	logic [VALUE_WIDTH-1:0]               value_q;
	logic [mdte_pkg::QIDX_FIELD_W-1:0]    src_q;
	logic                                 pop_back_q;
	logic [mdte_pkg::QIDX_FIELD_W-1:0]    dst_q;
	logic                                 push_back_q;

	logic [QIW-1:0] src_idx, dst_idx;

	// pointer ram
	logic           meta_we;
	logic [QIW-1:0] meta_waddr, meta_raddr;
	meta_t          meta_wdata;
	logic [MW-1:0]  meta_rdata;
	logic [QUEUE_COUNT-1:0] meta_valid_q;
	logic           meta_rvalid_s1;
	meta_t          meta_rec;
	meta_t          src_rec_q;

	// entry ram
	logic                   ent_we;
	logic [EAW-1:0]         ent_waddr, ent_raddr;
	logic [VALUE_WIDTH-1:0] ent_wdata, ent_rdata;

	// decision in ST_META2
	meta_t              s_rec, d_rec, src_new, base_rec, dst_new;
	meta_t              src_new_q, dst_new_q;
	logic               same_q, bad, empty, full, push_back_eff;
	logic [PW-1:0]      pop_slot, push_slot;
	logic [EAW-1:0]     pop_addr, push_addr, push_addr_q;
	mdte_pkg::status_t  dec_status;

	// result
	logic                               done_q;
	logic [mdte_pkg::VALUE_FIELD_W-1:0] moved_q;
	mdte_pkg::status_t                  status_q;

	assign busy        = !state_q[0];
	assign done        = done_q;
	assign moved_value = moved_q;
	assign status      = status_q;

	assign src_idx = QIW'(src_q);
	assign dst_idx = QIW'(dst_q);

	mdte_ram #(
		.WIDTH(MW),
		.DEPTH(QUEUE_COUNT)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	mdte_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(EDEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	// a queue never written since reset reads as empty with zero pointers
	assign meta_rec = meta_rvalid_s1 ? meta_t'(meta_rdata) : '0;

	// idle reads the source record, then the destination record follows
	assign meta_raddr = (state_q == ST_IDLE) ? QIW'(source_queue) : dst_idx;

	always_comb begin
		s_rec = src_rec_q;
		d_rec = meta_rec;

		bad   = (int'(dst_q) >= QUEUE_COUNT) || (mode_q && (int'(src_q) >= QUEUE_COUNT));
		empty = mode_q && (s_rec.count == '0);
		full  = !same_q && (int'(d_rec.count) >= QUEUE_DEPTH);

		if (bad) begin
			dec_status = mdte_pkg::STATUS_BAD_INDEX;
		end else if (empty) begin
			dec_status = mdte_pkg::STATUS_EMPTY;
		end else if (full) begin
			dec_status = mdte_pkg::STATUS_FULL;
		end else begin
			dec_status = mdte_pkg::STATUS_OK;
		end

		// pop side of a move
		pop_slot = pop_back_q ? s_rec.rear : s_rec.front;
		src_new  = s_rec;
		if (pop_back_q) begin
			src_new.rear = ptr_dec(s_rec.rear);
		end else begin
			src_new.front = ptr_inc(s_rec.front);
		end
		src_new.count = s_rec.count - 1'b1;

		// push side, on the popped record when both ends are one queue
		base_rec      = same_q ? src_new : d_rec;
		push_back_eff = mode_q ? push_back_q : 1'b1;
		dst_new       = base_rec;
		if (base_rec.count == '0) begin
			dst_new.front = '0;
			dst_new.rear  = '0;
			push_slot     = '0;
		end else if (push_back_eff) begin
			dst_new.rear = ptr_inc(base_rec.rear);
			push_slot    = dst_new.rear;
		end else begin
			dst_new.front = ptr_dec(base_rec.front);
			push_slot     = dst_new.front;
		end
		dst_new.count = base_rec.count + 1'b1;

		pop_addr  = EAW'(int'(src_idx) * QUEUE_DEPTH + int'(pop_slot));
		push_addr = EAW'(int'(dst_idx) * QUEUE_DEPTH + int'(push_slot));
	end

	always_comb begin
		state_d    = state_q;
		meta_we    = 1'b0;
		meta_waddr = dst_idx;
		meta_wdata = dst_new;
		ent_we     = 1'b0;
		ent_waddr  = push_addr;
		ent_wdata  = value_q;
		ent_raddr  = pop_addr;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_META1;
				end
			end
			ST_META1: begin
				state_d = ST_META2;
			end
			ST_META2: begin
				if (dec_status != mdte_pkg::STATUS_OK) begin
					state_d = ST_IDLE;
				end else if (!mode_q) begin
					meta_we = 1'b1;
					ent_we  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				meta_we    = 1'b1;
				meta_wdata = dst_new_q;
				ent_we     = 1'b1;
				ent_waddr  = push_addr_q;
				ent_wdata  = ent_rdata;
				state_d    = same_q ? ST_IDLE : ST_SRCWB;
			end
			ST_SRCWB: begin
				meta_we    = 1'b1;
				meta_waddr = src_idx;
				meta_wdata = src_new_q;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			meta_valid_q   <= '0;
			meta_rvalid_s1 <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			state_q        <= state_d;
			meta_rvalid_s1 <= meta_valid_q[meta_raddr];
			if (meta_we) begin
				meta_valid_q[meta_waddr] <= 1'b1;
			end
			done_q <= ((state_q == ST_META2) &&
				((dec_status != mdte_pkg::STATUS_OK) || !mode_q)) ||
				(state_q == ST_POP);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			mode_q      <= mode;
			value_q     <= VALUE_WIDTH'(value);
			src_q       <= source_queue;
			pop_back_q  <= pop_side;
			dst_q       <= dest_queue;
			push_back_q <= push_side;
			same_q      <= mode && (source_queue == dest_queue);
		end
		if (state_q == ST_META1) begin
			src_rec_q <= meta_rec;
		end
		if (state_q == ST_META2) begin
			src_new_q   <= src_new;
			dst_new_q   <= dst_new;
			push_addr_q <= push_addr;
			status_q    <= dec_status;
			moved_q     <= (dec_status == mdte_pkg::STATUS_OK) ?
				mdte_pkg::VALUE_FIELD_W'(value_q) : '0;
		end
		if (state_q == ST_POP) begin
			status_q <= mdte_pkg::STATUS_OK;
			moved_q  <= mdte_pkg::VALUE_FIELD_W'(ent_rdata);
		end
	end

	`MDTE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`MDTE_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without a word in flight")
	`MDTE_ASSERT_IMP(a_error_zero, done && (status != mdte_pkg::STATUS_OK), moved_value == '0,
		"refused word carried a value")
	`MDTE_ASSERT_IMP(a_write_busy, meta_we || ent_we, busy, "ram write while idle")
	`MDTE_ASSERT_IMP(a_count_range, meta_we, int'(meta_wdata.count) <= QUEUE_DEPTH,
		"queue count beyond depth")

endmodule

FILE: test/tb.sv
// testbench for multi_deque_transfer_engine: a directed table, then random words checked
// against an in-bench model of the deque bank
// depends on mdte_pkg and the engine rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = mdte_pkg::QUEUE_DEPTH_DEF;
	localparam int COUNT = mdte_pkg::QUEUE_COUNT_DEF;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_MOVE = 1'b1;
	localparam logic SIDE_FRONT = 1'b0;
	localparam logic SIDE_BACK = 1'b1;
	localparam int RANDOM_WORDS = 1700;
	localparam int PHASE_WORDS = 60;
	localparam int BANK_SOFT_CAP = 44;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic       mode;
		logic [7:0] value;
		logic [2:0] src;
		logic       pop_side;
		logic [2:0] dst;
		logic       push_side;
	} deque_cmd_t;

	typedef struct packed {
		logic [7:0]        value;
		mdte_pkg::status_t status;
	} transfer_result_t;

	typedef struct packed {
		deque_cmd_t       cmd;
		logic             checked;
		transfer_result_t result;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic mode;
	logic [mdte_pkg::VALUE_FIELD_W-1:0] value;
	logic [mdte_pkg::QIDX_FIELD_W-1:0] source_queue;
	logic pop_side;
	logic [mdte_pkg::QIDX_FIELD_W-1:0] dest_queue;
	logic push_side;
	logic done;
	logic [mdte_pkg::VALUE_FIELD_W-1:0] moved_value;
	logic [1:0] status;

	multi_deque_transfer_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value(value),
		.source_queue(source_queue),
		.pop_side(pop_side),
		.dest_queue(dest_queue),
		.push_side(push_side),
		.done(done),
		.moved_value(moved_value),
		.status(status)
	);

	// model of the deque bank
	logic [7:0] slot_data [COUNT][DEPTH];
	int front_idx [COUNT] = '{default: 0};
	int rear_idx [COUNT] = '{default: 0};
	int fill [COUNT] = '{default: 0};

	transfer_result_t awaited_results [$];
	int mismatch_count = 0;
	int stall_cycles = 0;
	bit allow_idle = 1'b1;

	// checked rows carry a result that is plain from the command; the rest use the model
	directed_row_t directed_rows [22] = '{
		'{'{MODE_MOVE, 8'hA5, 3'd0, SIDE_FRONT, 3'd1, SIDE_BACK}, 1'b1,
			'{8'h00, mdte_pkg::STATUS_EMPTY}},
		'{'{MODE_LOAD, 8'h00, 3'd0, SIDE_FRONT, 3'd7, SIDE_FRONT}, 1'b1,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'hFF, 3'd7, SIDE_BACK, 3'd7, SIDE_FRONT}, 1'b1,
			'{8'hFF, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'h5A, 3'd7, SIDE_BACK, 3'd0, SIDE_FRONT}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'h00, 3'd7, SIDE_FRONT, 3'd7, SIDE_BACK}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h01, 3'd0, SIDE_FRONT, 3'd2, SIDE_FRONT}, 1'b1,
			'{8'h01, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h02, 3'd5, SIDE_BACK, 3'd2, SIDE_BACK}, 1'b1,
			'{8'h02, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h04, 3'd0, SIDE_FRONT, 3'd2, SIDE_FRONT}, 1'b1,
			'{8'h04, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h08, 3'd3, SIDE_BACK, 3'd2, SIDE_BACK}, 1'b1,
			'{8'h08, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h10, 3'd0, SIDE_FRONT, 3'd2, SIDE_FRONT}, 1'b1,
			'{8'h10, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h20, 3'd6, SIDE_BACK, 3'd2, SIDE_BACK}, 1'b1,
			'{8'h20, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h40, 3'd0, SIDE_FRONT, 3'd2, SIDE_FRONT}, 1'b1,
			'{8'h40, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h80, 3'd1, SIDE_BACK, 3'd2, SIDE_BACK}, 1'b1,
			'{8'h80, mdte_pkg::STATUS_OK}},
		'{'{MODE_LOAD, 8'h7E, 3'd0, SIDE_FRONT, 3'd2, SIDE_BACK}, 1'b1,
			'{8'h00, mdte_pkg::STATUS_FULL}},
		'{'{MODE_MOVE, 8'hA5, 3'd2, SIDE_FRONT, 3'd2, SIDE_FRONT}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'hA5, 3'd2, SIDE_BACK, 3'd2, SIDE_BACK}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'hA5, 3'd0, SIDE_FRONT, 3'd2, SIDE_BACK}, 1'b1,
			'{8'h00, mdte_pkg::STATUS_FULL}},
		'{'{MODE_MOVE, 8'hA5, 3'd2, SIDE_BACK, 3'd3, SIDE_FRONT}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'hA5, 3'd2, SIDE_FRONT, 3'd3, SIDE_BACK}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'hA5, 3'd3, SIDE_BACK, 3'd3, SIDE_FRONT}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'hA5, 3'd0, SIDE_BACK, 3'd7, SIDE_BACK}, 1'b0,
			'{8'h00, mdte_pkg::STATUS_OK}},
		'{'{MODE_MOVE, 8'hFF, 3'd0, SIDE_FRONT, 3'd5, SIDE_FRONT}, 1'b1,
			'{8'h00, mdte_pkg::STATUS_EMPTY}}
	};

	function automatic void push_entry(int q, logic at_back, logic [7:0] v);
		int slot;
		// an empty queue restarts at slot zero
		if (fill[q] == 0) begin
			front_idx[q] = 0;
			rear_idx[q] = 0;
			slot = 0;
		end else if (at_back == SIDE_BACK) begin
			rear_idx[q] = (rear_idx[q] + 1) % DEPTH;
			slot = rear_idx[q];
		end else begin
			front_idx[q] = (front_idx[q] + DEPTH - 1) % DEPTH;
			slot = front_idx[q];
		end
		slot_data[q][slot] = v;
		fill[q]++;
	endfunction

	function automatic transfer_result_t transfer_outcome(deque_cmd_t c);
		transfer_result_t r;
		int s;
		int d;
		r = '{8'h00, mdte_pkg::STATUS_OK};
		s = int'(c.src);
		d = int'(c.dst);
		if (c.mode == MODE_LOAD) begin
			if (d >= COUNT) begin
				r.status = mdte_pkg::STATUS_BAD_INDEX;
			end else if (fill[d] >= DEPTH) begin
				r.status = mdte_pkg::STATUS_FULL;
			end else begin
				push_entry(d, SIDE_BACK, c.value);
				r.value = c.value;
			end
		end else if (s >= COUNT || d >= COUNT) begin
			r.status = mdte_pkg::STATUS_BAD_INDEX;
		end else if (fill[s] == 0) begin
			r.status = mdte_pkg::STATUS_EMPTY;
		end else if (s != d && fill[d] >= DEPTH) begin
			// full is judged before the pop, a move within one queue always fits
			r.status = mdte_pkg::STATUS_FULL;
		end else begin
			if (c.pop_side == SIDE_BACK) begin
				r.value = slot_data[s][rear_idx[s]];
				rear_idx[s] = (rear_idx[s] + DEPTH - 1) % DEPTH;
			end else begin
				r.value = slot_data[s][front_idx[s]];
				front_idx[s] = (front_idx[s] + 1) % DEPTH;
			end
			fill[s]--;
			push_entry(d, c.push_side, r.value);
		end
		return r;
	endfunction

	task automatic drive_word(deque_cmd_t c, logic checked, transfer_result_t typed_result);
		transfer_result_t r;
		if (allow_idle && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= c.mode;
		value <= c.value;
		source_queue <= c.src;
		pop_side <= c.pop_side;
		dest_queue <= c.dst;
		push_side <= c.push_side;
		@(posedge clk);
		while (busy) @(posedge clk);
		// word taken at this edge
		r = transfer_outcome(c);
		awaited_results.push_back(checked ? typed_result : r);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		deque_cmd_t c;
		int hot_a;
		int hot_b;
		bit filling;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_LOAD;
		value = '0;
		source_queue = '0;
		pop_side = SIDE_FRONT;
		dest_queue = '0;
		push_side = SIDE_FRONT;
		hot_a = 0;
		hot_b = 1;
		filling = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_word(directed_rows[i].cmd, directed_rows[i].checked, directed_rows[i].result);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// each phase picks a pair of queues and, at random, whether to pile words onto or drain them
			if (n % PHASE_WORDS == 0) begin
				hot_a = int'($urandom_range(COUNT - 1));
				hot_b = int'($urandom_range(COUNT - 1));
				filling = 1'($urandom_range(1));
			end
			allow_idle = !(n >= 700 && n < 1000);
			c.mode = ($urandom_range(99) < (filling ? 60 : 20)) ? MODE_LOAD : MODE_MOVE;
			c.value = 8'($urandom_range(255));
			c.pop_side = 1'($urandom_range(1));
			c.push_side = 1'($urandom_range(1));
			c.src = 3'($urandom_range(COUNT - 1));
			c.dst = 3'($urandom_range(COUNT - 1));
			if ($urandom_range(99) < 70) begin
				if (filling)
					c.dst = $urandom_range(1) ? 3'(hot_a) : 3'(hot_b);
				else
					c.src = $urandom_range(1) ? 3'(hot_a) : 3'(hot_b);
			end
			if ($urandom_range(99) < 15)
				c.dst = c.src;
			// loads only add words, so keep the bank from filling up for good
			if (c.mode == MODE_LOAD && fill.sum() >= BANK_SOFT_CAP && fill[c.dst] < DEPTH)
				c.mode = MODE_MOVE;
			drive_word(c, 1'b0, '{8'h00, mdte_pkg::STATUS_OK});
		end
		start <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		transfer_result_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got value %0h status %0d",
						$time, moved_value, status);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (moved_value !== want.value) begin
						$display("%0t: moved_value expected %0h got %0h",
							$time, want.value, moved_value);
						mismatch_count++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
						mismatch_count++;
					end
				end
			end
			if ((start && !busy) || done) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

endmodule

FILE: files.f
+incdir+sv
sv/mdte_pkg.sv
sv/mdte_ram.sv
sv/multi_deque_transfer_engine.sv
test/tb.sv
